### sv/sga_pkg.sv
// shared types and constants of the softened gravity accumulator
`default_nettype none
package sga_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned SumW   = 48;
  localparam int unsigned R2W    = 42;
  localparam int unsigned RootW  = 29;
  localparam int unsigned SqW    = 59;
  localparam int unsigned DenW   = 71;
  localparam int unsigned GmW    = 64;
  localparam int unsigned ProdW  = 96;
  localparam int unsigned NumW   = 108;
  localparam int unsigned AddrW  = 3;

  localparam logic [DataW-1:0] GravReset = 32'd65536;
  localparam logic [DataW-1:0] SoftReset = 32'd16777;

  // register index taken from the word address bit
  localparam logic RegGrav = 1'b0;
  localparam logic RegSoft = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MX,
    ST_MY,
    ST_MZ,
    ST_MG,
    ST_CHK,
    ST_SQ,
    ST_D0,
    ST_D1,
    ST_D2,
    ST_N0,
    ST_N1,
    ST_N2,
    ST_DS,
    ST_DV,
    ST_FIN
  } st_e;

endpackage
`default_nettype wire

### sv/sga_if.sv
// item and result channel interfaces
`default_nettype none
interface sga_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic signed [31:0] source_x;
  logic signed [31:0] source_y;
  logic signed [31:0] source_z;
  logic [31:0]        source_mass;
  logic               last_source;

  modport source (output valid, target_x, target_y, target_z, source_x, source_y,
                  source_z, source_mass, last_source, input ready);
  modport sink (input valid, target_x, target_y, target_z, source_x, source_y,
                source_z, source_mass, last_source, output ready);
endinterface

interface sga_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] accel_x;
  logic signed [47:0] accel_y;
  logic signed [47:0] accel_z;
  logic               saturated;

  modport source (output valid, accel_x, accel_y, accel_z, saturated, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, saturated, output ready);
endinterface
`default_nettype wire

### sv/softened_gravity_accumulator.sv
// top level: sequencer, shared units, accumulator and register port
// one item passes these steps in order: squares of the offsets and G*m, the r^2 = 0 check,
//   the square root, r^3, then per axis the numerator multiply and a bit-serial division, then finish
// each division yields 108 quotient bits per axis; an item with r^2 = 0 skips straight to finish
// one item in flight; a last source also waits in the finish state for a free output register
// reset clears the sums, the saturation flag and loads G = 1.0, eps = 16777
`default_nettype none
module softened_gravity_accumulator (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  sga_in_if.sink                    item_i,
  sga_out_if.source                 result_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [sga_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import sga_pkg::*;

  st_e state_q, state_d;

  logic [DataW-1:0] grav_q, soft_q;
  logic [DataW-1:0] mag_q [3];
  logic             neg_q [3];
  logic [DataW-1:0] mass_q;
  logic             last_q;
  logic [R2W-1:0]   r2_q;
  logic [GmW-1:0]   gm_q;
  logic [RootW-1:0] root_q;
  logic [DenW-1:0]  den_q;
  logic [ProdW-1:0] num_q;
  logic [1:0]       axis_q;
  logic signed [SumW-1:0] sum_q [3];
  logic             ovf_q;
  logic             out_valid_q;
  logic signed [SumW-1:0] out_x_q, out_y_q, out_z_q;
  logic             out_sat_q;

  logic [DataW-1:0] mul_a, mul_b;
  logic [2*DataW-1:0] prod;
  logic             sq_start, sq_done, div_start, div_busy, div_done;
  logic [RootW-1:0] sq_root;
  logic [NumW-1:0]  quo;
  logic             emit_ok, item_fire;
  logic signed [DataW:0] dx, dy, dz;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegSoft) ? soft_q : grav_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= GravReset;
      soft_q <= SoftReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegSoft) begin
        soft_q <= pwdata;
      end else begin
        grav_q <= pwdata;
      end
    end
  end

  // shared units
  sga_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  sga_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   ({r2_q, 16'd0}),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  sga_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({num_q, 12'd0}),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign emit_ok   = !out_valid_q || result_o.ready;
  assign item_fire = item_i.valid && item_i.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (item_i.valid) state_d = ST_MX;
      ST_MX:   state_d = ST_MY;
      ST_MY:   state_d = ST_MZ;
      ST_MZ:   state_d = ST_MG;
      ST_MG:   state_d = ST_CHK;
      ST_CHK:  state_d = (r2_q == '0) ? ST_FIN : ST_SQ;
      ST_SQ:   if (sq_done) state_d = ST_D0;
      ST_D0:   state_d = ST_D1;
      ST_D1:   state_d = ST_D2;
      ST_D2:   state_d = ST_N0;
      ST_N0:   state_d = ST_N1;
      ST_N1:   state_d = ST_N2;
      ST_N2:   state_d = ST_DS;
      ST_DS:   state_d = ST_DV;
      ST_DV:   if (div_done) state_d = (axis_q == 2'd2) ? ST_FIN : ST_N0;
      ST_FIN:  if (!last_q || emit_ok) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, unit starts and item ready
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    sq_start  = 1'b0;
    div_start = 1'b0;
    item_i.ready = 1'b0;
    unique case (state_q)
      ST_IDLE: item_i.ready = 1'b1;
      ST_MX:   begin mul_a = mag_q[0]; mul_b = mag_q[0]; end
      ST_MY:   begin mul_a = mag_q[1]; mul_b = mag_q[1]; end
      ST_MZ:   begin mul_a = mag_q[2]; mul_b = mag_q[2]; end
      ST_MG:   begin mul_a = grav_q; mul_b = mass_q; end
      ST_CHK:  sq_start = (r2_q != '0);
      ST_D0:   begin mul_a = r2_q[DataW-1:0]; mul_b = DataW'(root_q); end
      ST_D1:   begin mul_a = DataW'(r2_q[R2W-1:DataW]); mul_b = DataW'(root_q); end
      ST_N0:   begin mul_a = gm_q[DataW-1:0]; mul_b = mag_q[axis_q]; end
      ST_N1:   begin mul_a = gm_q[GmW-1:DataW]; mul_b = mag_q[axis_q]; end
      ST_DS:   div_start = 1'b1;
      default: ;
    endcase
  end

  // per-axis add with cap and saturation
  logic              cap_hit;
  logic [SumW:0]     contrib;
  logic signed [SumW+1:0] acc_ext, acc_new;
  logic signed [SumW-1:0] acc_sat;
  logic              acc_ovf;

  always_comb begin
    cap_hit = (quo[NumW-1:SumW+1] != '0) || (quo[SumW] && (quo[SumW-1:0] != '0));
    contrib = cap_hit ? {1'b1, {SumW{1'b0}}} : quo[SumW:0];
    acc_ext = (SumW+2)'(sum_q[axis_q]);
    if (neg_q[axis_q]) begin
      acc_new = acc_ext - $signed({1'b0, contrib});
    end else begin
      acc_new = acc_ext + $signed({1'b0, contrib});
    end
    acc_ovf = 1'b1;
    if (acc_new > $signed({3'b000, {(SumW-1){1'b1}}})) begin
      acc_sat = {1'b0, {(SumW-1){1'b1}}};
    end else if (acc_new < $signed({3'b111, {(SumW-1){1'b0}}})) begin
      acc_sat = {1'b1, {(SumW-1){1'b0}}};
    end else begin
      acc_sat = acc_new[SumW-1:0];
      acc_ovf = 1'b0;
    end
  end

  assign dx = $signed({item_i.source_x[31], item_i.source_x})
            - $signed({item_i.target_x[31], item_i.target_x});
  assign dy = $signed({item_i.source_y[31], item_i.source_y})
            - $signed({item_i.target_y[31], item_i.target_y});
  assign dz = $signed({item_i.source_z[31], item_i.source_z})
            - $signed({item_i.target_z[31], item_i.target_z});

  // control state: sequencer, sums, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 2'd0;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      sum_q[2]    <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_D2) begin
        axis_q <= 2'd0;
      end
      if (state_q == ST_DV && div_done) begin
        sum_q[axis_q] <= acc_sat;
        if (acc_ovf) ovf_q <= 1'b1;
        if (axis_q != 2'd2) axis_q <= axis_q + 2'd1;
      end
      if (state_q == ST_FIN && last_q && emit_ok) begin
        out_valid_q <= 1'b1;
        sum_q[0]    <= '0;
        sum_q[1]    <= '0;
        sum_q[2]    <= '0;
        ovf_q       <= 1'b0;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (item_fire) begin
      mag_q[0] <= dx[DataW] ? DataW'(-dx) : dx[DataW-1:0];
      mag_q[1] <= dy[DataW] ? DataW'(-dy) : dy[DataW-1:0];
      mag_q[2] <= dz[DataW] ? DataW'(-dz) : dz[DataW-1:0];
      neg_q[0] <= dx[DataW];
      neg_q[1] <= dy[DataW];
      neg_q[2] <= dz[DataW];
      mass_q   <= item_i.source_mass;
      last_q   <= item_i.last_source;
      r2_q     <= R2W'(soft_q);
    end
    if (state_q == ST_MY || state_q == ST_MZ || state_q == ST_MG) begin
      r2_q <= r2_q + R2W'(prod[2*DataW-1:24]);
    end
    if (state_q == ST_CHK) gm_q <= prod;
    if (state_q == ST_SQ && sq_done) root_q <= sq_root;
    if (state_q == ST_D1) den_q <= DenW'(prod);
    if (state_q == ST_D2) den_q <= den_q + {prod[38:0], 32'd0};
    if (state_q == ST_N1) num_q <= ProdW'(prod);
    if (state_q == ST_N2) num_q <= num_q + {prod, 32'd0};
    if (state_q == ST_FIN && last_q && emit_ok) begin
      out_x_q   <= sum_q[0];
      out_y_q   <= sum_q[1];
      out_z_q   <= sum_q[2];
      out_sat_q <= ovf_q;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.accel_x   = out_x_q;
  assign result_o.accel_y   = out_y_q;
  assign result_o.accel_z   = out_z_q;
  assign result_o.saturated = out_sat_q;

  // divider is never restarted while it is still working
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  // the axis index never leaves the three axes
  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q != 2'd3) else $error("axis index out of range");

  // a new result appears only after a last source
  a_emit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(last_q)) else $error("result without last source");

  // sums are cleared once a result is loaded (checked on the x sum and the saturation flag)
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && last_q && emit_ok) |=> (sum_q[0] == '0 && !ovf_q))
    else $error("accumulator not cleared after emit");

endmodule
`default_nettype wire

### sv/sga_mul.sv
// shared 32x32 unsigned multiplier with registered product
`default_nettype none
module sga_mul (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [63:0]      prod_o
);
  import sga_pkg::*;

  logic [2*DataW-1:0] prod_q;

  // product register
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

### sv/sga_sqrt.sv
// digit-by-digit integer square root, one result bit per cycle
`default_nettype none
module sga_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [57:0] val_i,
  output logic             done_o,
  output logic [28:0]      root_o
);
  import sga_pkg::*;

  logic [SqW-1:0] v_q, v_d, res_q, res_d, bit_q, bit_d, trial;
  logic           done_q, done_d;

  // one digit step
  always_comb begin
    trial  = res_q + bit_q;
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d   = {1'b0, val_i};
      res_d = '0;
      bit_d = {1'b1, {(SqW-1){1'b0}}};
    end else if (bit_q != '0) begin
      if (v_q >= trial) begin
        v_d   = v_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d  = bit_q >> 2;
      done_d = (bit_q == {{(SqW-1){1'b0}}, 1'b1});
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      done_q <= 1'b0;
    end else begin
      bit_q  <= bit_d;
      done_q <= done_d;
    end
  end

  // working value and root
  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[RootW-1:0];

endmodule
`default_nettype wire

### sv/sga_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module sga_div (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [107:0] num_i,
  input  wire logic [70:0]  den_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [107:0]      quo_o
);
  import sga_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] nq_q, nq_d;
  logic [DenW-1:0] rem_q, rem_d, den_q;
  logic [DenW:0]   rem_sh;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d, qbit;

  // shift in one numerator bit, trial subtract
  always_comb begin
    rem_sh = {rem_q, nq_q[NumW-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    nq_d   = nq_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      nq_d  = num_i;
      rem_d = '0;
      cnt_d = CntW'(NumW);
    end else if (cnt_q != '0) begin
      rem_d  = qbit ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
      nq_d   = {nq_q[NumW-2:0], qbit};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule
`default_nettype wire
